>>> rtl/core/nxs_pkg.sv
// shared types, constants and codes for the cross-section interpolator
package nxs_pkg;

	localparam int MAX_NUCLIDES = 16;
	localparam int MAX_POINTS   = 1024;

	localparam int NK_W   = $clog2(MAX_NUCLIDES);
	localparam int NC_W   = $clog2(MAX_NUCLIDES + 1);
	localparam int PA_W   = $clog2(MAX_POINTS);
	localparam int PC_W   = $clog2(MAX_POINTS + 1);
	localparam int E_W    = 40;
	localparam int S_W    = 32;
	localparam int KEY_W  = 16;
	localparam int MEV_W  = 11;
	localparam int QE_W   = 31;
	localparam int NUM_W  = QE_W + S_W;
	localparam int DCNT_W = $clog2(NUM_W);

	localparam logic [19:0] EV_PER_MEV = 20'd1000000;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]       op;
		logic [6:0]       atomic_number;
		logic [8:0]       mass_number;
		logic [E_W-1:0]   point_energy_ev;
		logic [S_W-1:0]   point_sigma;
		logic [MEV_W-1:0] query_mev;
	} req_t;

	typedef struct packed {
		logic [S_W-1:0] sigma_out;
		logic [1:0]     status;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_KEY, S_WALK, S_SLO, S_SHI, S_MUL, S_DIV, S_FIN, S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic query;
		logic key_step;
		logic walk_init;
		logic walk_run;
		logic sig_lo;
		logic sig_hi;
		logic mul;
		logic div_step;
		logic fin;
		logic set_zero;
		logic set_nf;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic key_hit;
		logic key_miss;
		logic walk_hit;
		logic walk_zero;
		logic div_done;
	} sts_t;

endpackage

>>> rtl/core/nuclide_cross_section_interpolator.sv
// A start or append goes to S_DONE and is answered once the output register is free.
// A query searches K directory entries (up to 16), walks L points (up to 1024)
// of the matched table, reads both bracket sigmas, multiplies, divides and finishes.
// Throughput: one item at a time; the point walk on the energy ram read port
// and the one-bit-per-cycle divider bound how soon the next item is taken.
// Reset: arst_n clears the nuclide and point counts and all control; no clearing pass.
module nuclide_cross_section_interpolator (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  nxs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output nxs_pkg::rsp_t rsp
);
	nxs_pkg::cmd_t               cmd;
	nxs_pkg::sts_t               sts;
	logic                        ram_we;
	logic [nxs_pkg::PA_W-1:0]    ram_waddr, e_raddr, s_raddr;
	logic [nxs_pkg::E_W-1:0]     e_rdata;
	logic [nxs_pkg::S_W-1:0]     s_rdata;

	// sequencer
	nxs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath
	nxs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.e_raddr   (e_raddr),
		.e_rdata   (e_rdata),
		.s_raddr   (s_raddr),
		.s_rdata   (s_rdata),
		.rsp       (rsp)
	);

	// point energy store
	nxs_ram #(.WIDTH(nxs_pkg::E_W), .DEPTH(nxs_pkg::MAX_POINTS)) u_energy_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.point_energy_ev),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	// point cross-section store
	nxs_ram #(.WIDTH(nxs_pkg::S_W), .DEPTH(nxs_pkg::MAX_POINTS)) u_sigma_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (req.point_sigma),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);
endmodule

>>> rtl/core/nxs_ram.sv
// generic single-write, single-read ram with registered read data
module nxs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/nxs_ctrl.sv
// sequencer for loads and the query walk, divide and result hand-off
module nxs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic [1:0]     req_op,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	input  nxs_pkg::sts_t  sts,
	output nxs_pkg::cmd_t  cmd
);
	nxs_pkg::state_t state_q, state_d;
	logic            rsp_valid_q;
	logic            out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nxs_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			nxs_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_op == nxs_pkg::OP_QUERY) begin
						cmd.query = 1'b1;
						state_d   = nxs_pkg::S_KEY;
					end else begin
						cmd.load = 1'b1;
						state_d  = nxs_pkg::S_DONE;
					end
				end
			end
			nxs_pkg::S_KEY: begin
				if (sts.key_miss) begin
					cmd.set_nf = 1'b1;
					state_d    = nxs_pkg::S_DONE;
				end else if (sts.key_hit) begin
					cmd.walk_init = 1'b1;
					state_d       = nxs_pkg::S_WALK;
				end else begin
					cmd.key_step = 1'b1;
				end
			end
			nxs_pkg::S_WALK: begin
				cmd.walk_run = 1'b1;
				if (sts.walk_zero) begin
					cmd.set_zero = 1'b1;
					state_d      = nxs_pkg::S_DONE;
				end else if (sts.walk_hit) begin
					state_d = nxs_pkg::S_SLO;
				end
			end
			nxs_pkg::S_SLO: begin
				cmd.sig_lo = 1'b1;
				state_d    = nxs_pkg::S_SHI;
			end
			nxs_pkg::S_SHI: begin
				cmd.sig_hi = 1'b1;
				state_d    = nxs_pkg::S_MUL;
			end
			nxs_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = nxs_pkg::S_DIV;
			end
			nxs_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = nxs_pkg::S_FIN;
				end
			end
			nxs_pkg::S_FIN: begin
				cmd.fin = 1'b1;
				state_d = nxs_pkg::S_DONE;
			end
			nxs_pkg::S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = nxs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nxs_pkg::S_IDLE;
			end
		endcase
	end
endmodule

>>> rtl/core/nxs_dp.sv
// datapath: nuclide directory, point walk, multiply, serial divide, result
module nxs_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nxs_pkg::req_t              req,
	input  nxs_pkg::cmd_t              cmd,
	output nxs_pkg::sts_t              sts,
	output logic                       ram_we,
	output logic [nxs_pkg::PA_W-1:0]   ram_waddr,
	output logic [nxs_pkg::PA_W-1:0]   e_raddr,
	input  logic [nxs_pkg::E_W-1:0]    e_rdata,
	output logic [nxs_pkg::PA_W-1:0]   s_raddr,
	input  logic [nxs_pkg::S_W-1:0]    s_rdata,
	output nxs_pkg::rsp_t              rsp
);
	// nuclide directory
	logic [nxs_pkg::KEY_W-1:0] keys_q  [nxs_pkg::MAX_NUCLIDES];
	logic [nxs_pkg::PC_W-1:0]  start_q [nxs_pkg::MAX_NUCLIDES];
	logic [nxs_pkg::PC_W-1:0]  len_q   [nxs_pkg::MAX_NUCLIDES];
	logic [nxs_pkg::NC_W-1:0]  ncount_q;
	logic [nxs_pkg::PC_W-1:0]  pcount_q;

	// query state
	logic [nxs_pkg::KEY_W-1:0] key_q;
	logic [nxs_pkg::QE_W-1:0]  qe_q;
	logic [nxs_pkg::NC_W-1:0]  kidx_q;
	logic [nxs_pkg::PC_W-1:0]  tstart_q, tlen_q, idx_q, pidx_s1, hi_q;
	logic                      v_s1;
	logic [nxs_pkg::E_W-1:0]   prev_q, elo_q, de_q;
	logic [nxs_pkg::S_W-1:0]   s0_q;
	logic                      neg_q;
	logic [nxs_pkg::NUM_W-1:0] num_q;
	logic [nxs_pkg::E_W:0]     rem_q;
	logic [nxs_pkg::DCNT_W-1:0] dcnt_q;
	nxs_pkg::rsp_t             res_q, rsp_q;

	logic [nxs_pkg::KEY_W-1:0] req_key;
	logic                      full_n, full_p, no_tab;
	logic [nxs_pkg::E_W-1:0]   qe_ext;
	logic                      e_le, e_lt, last_pt;
	logic [nxs_pkg::QE_W-1:0]  dx;
	logic [nxs_pkg::S_W-1:0]   ds;
	logic [nxs_pkg::E_W:0]     rem_sh;
	logic                      qbit;
	logic [nxs_pkg::PC_W-1:0]  hi_abs;

	assign req_key = {req.atomic_number, req.mass_number};
	assign full_n  = ncount_q == nxs_pkg::NC_W'(nxs_pkg::MAX_NUCLIDES);
	assign full_p  = pcount_q == nxs_pkg::PC_W'(nxs_pkg::MAX_POINTS);
	assign no_tab  = ncount_q == '0;

	// point store write on a good append
	assign ram_we    = cmd.load && req.op == nxs_pkg::OP_APPEND && !no_tab && !full_p;
	assign ram_waddr = pcount_q[nxs_pkg::PA_W-1:0];

	// directory search status
	assign sts.key_miss = kidx_q >= ncount_q;
	assign sts.key_hit  = !sts.key_miss && keys_q[kidx_q[nxs_pkg::NK_W-1:0]] == key_q;

	// point walk compare on the returned energy
	assign qe_ext  = nxs_pkg::E_W'(qe_q);
	assign e_le    = qe_ext <= e_rdata;
	assign e_lt    = qe_ext < e_rdata;
	assign last_pt = pidx_s1 == tlen_q - nxs_pkg::PC_W'(1);
	assign e_raddr = nxs_pkg::PA_W'(tstart_q + idx_q);
	assign sts.walk_zero = tlen_q == '0 ||
		(v_s1 && (pidx_s1 == '0 ? (e_le || last_pt) : (!e_lt && last_pt)));
	assign sts.walk_hit  = tlen_q != '0 && v_s1 && pidx_s1 != '0 && e_lt;

	// sigma reads at the bracket
	assign hi_abs  = tstart_q + hi_q;
	assign s_raddr = cmd.sig_lo ? nxs_pkg::PA_W'(hi_abs - nxs_pkg::PC_W'(1))
		: nxs_pkg::PA_W'(hi_abs);

	// multiply operands
	assign dx = qe_q - elo_q[nxs_pkg::QE_W-1:0];
	assign ds = (s_rdata >= s0_q) ? s_rdata - s0_q : s0_q - s_rdata;

	// restoring divide step
	assign rem_sh = {rem_q[nxs_pkg::E_W-1:0], num_q[nxs_pkg::NUM_W-1]};
	assign qbit   = rem_sh >= {1'b0, de_q};
	assign sts.div_done = dcnt_q == nxs_pkg::DCNT_W'(nxs_pkg::NUM_W - 1);

	assign rsp = rsp_q;

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncount_q <= '0;
			pcount_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			if (cmd.load && req.op == nxs_pkg::OP_START && !full_n) begin
				ncount_q <= ncount_q + nxs_pkg::NC_W'(1);
			end
			if (ram_we) begin
				pcount_q <= pcount_q + nxs_pkg::PC_W'(1);
			end
			if (cmd.walk_init) begin
				v_s1 <= 1'b0;
			end else if (cmd.walk_run) begin
				v_s1 <= 1'b1;
			end
		end
	end

	// directory and query datapath
	always_ff @(posedge clk) begin
		if (cmd.load && req.op == nxs_pkg::OP_START && !full_n) begin
			keys_q[ncount_q[nxs_pkg::NK_W-1:0]]  <= req_key;
			start_q[ncount_q[nxs_pkg::NK_W-1:0]] <= pcount_q;
			len_q[ncount_q[nxs_pkg::NK_W-1:0]]   <= '0;
		end
		if (ram_we) begin
			len_q[nxs_pkg::NK_W'(ncount_q - nxs_pkg::NC_W'(1))] <=
				len_q[nxs_pkg::NK_W'(ncount_q - nxs_pkg::NC_W'(1))] + nxs_pkg::PC_W'(1);
		end

		// result for loads
		if (cmd.load) begin
			res_q.sigma_out <= '0;
			res_q.status    <= nxs_pkg::ST_OK;
			if (req.op == nxs_pkg::OP_START && full_n) begin
				res_q.status <= nxs_pkg::ST_FULL;
			end else if (req.op == nxs_pkg::OP_APPEND) begin
				if (no_tab) begin
					res_q.status <= nxs_pkg::ST_NOT_FOUND;
				end else if (full_p) begin
					res_q.status <= nxs_pkg::ST_FULL;
				end
			end
		end

		// query start: key and energy in ev
		if (cmd.query) begin
			key_q  <= req_key;
			qe_q   <= nxs_pkg::QE_W'(req.query_mev) * nxs_pkg::QE_W'(nxs_pkg::EV_PER_MEV);
			kidx_q <= '0;
		end
		if (cmd.key_step) begin
			kidx_q <= kidx_q + nxs_pkg::NC_W'(1);
		end

		// table walk
		if (cmd.walk_init) begin
			tstart_q <= start_q[kidx_q[nxs_pkg::NK_W-1:0]];
			tlen_q   <= len_q[kidx_q[nxs_pkg::NK_W-1:0]];
			idx_q    <= '0;
		end
		if (cmd.walk_run) begin
			idx_q   <= idx_q + nxs_pkg::PC_W'(1);
			pidx_s1 <= idx_q;
			if (v_s1) begin
				prev_q <= e_rdata;
			end
			if (sts.walk_hit) begin
				hi_q  <= pidx_s1;
				elo_q <= prev_q;
				de_q  <= e_rdata - prev_q;
			end
		end

		// bracket sigmas and product
		if (cmd.sig_hi) begin
			s0_q <= s_rdata;
		end
		if (cmd.mul) begin
			num_q  <= nxs_pkg::NUM_W'(dx) * nxs_pkg::NUM_W'(ds);
			neg_q  <= s_rdata < s0_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= qbit ? rem_sh - {1'b0, de_q} : rem_sh;
			num_q  <= {num_q[nxs_pkg::NUM_W-2:0], qbit};
			dcnt_q <= dcnt_q + nxs_pkg::DCNT_W'(1);
		end

		// query results
		if (cmd.fin) begin
			res_q.sigma_out <= neg_q ? s0_q - num_q[nxs_pkg::S_W-1:0]
				: s0_q + num_q[nxs_pkg::S_W-1:0];
			res_q.status    <= nxs_pkg::ST_OK;
		end
		if (cmd.set_zero) begin
			res_q.sigma_out <= '0;
			res_q.status    <= nxs_pkg::ST_OK;
		end
		if (cmd.set_nf) begin
			res_q.sigma_out <= '0;
			res_q.status    <= nxs_pkg::ST_NOT_FOUND;
		end

		// output register
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end
endmodule

>>> rtl/core/nxs_checker.sv
// port-level checks for the interpolator, bound to the top level
module nxs_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input nxs_pkg::rsp_t rsp
);
	// a stalled response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one item at a time: after a request transfer the input stalls
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while busy");

	// status code is never the unused value
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3)
		else $error("bad status code");

	// error responses carry zero cross section
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != nxs_pkg::ST_OK |-> rsp.sigma_out == '0)
		else $error("error response with nonzero sigma");
endmodule

bind nuclide_cross_section_interpolator nxs_checker u_nxs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
